// ===== rtl/core/lfuc_pkg.sv =====
`timescale 1ns / 1ps

package lfuc_pkg;

  // Fixed field widths
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

endpackage

// ===== rtl/core/lfu_cache_lru_tiebreak.sv =====
`timescale 1ns / 1ps

// Key-value cache of ENTRIES slots with least-frequently-used replacement and
// a least-recently-used tie break, built as a chain of entry cells kept in
// victim order (highest count first, most recent first within a count), so
// the victim is always the last valid cell. A transaction passes a look
// state, comparing the key against every cell, then an update state that
// commits the shift of the cell chain and registers the result, held while
// an earlier result is stalled at the output. A new transaction is taken
// when idle or as the previous one finishes. The capacity register (reset 16,
// values above ENTRIES act as ENTRIES, zero disables puts) must only be
// written while the cache is idle. No clearing pass follows reset.
module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lfuc_pkg::CAP_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic signed [lfuc_pkg::KEY_W-1:0]  key,
  input  logic signed [lfuc_pkg::VAL_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [lfuc_pkg::VAL_W-1:0]  read_value,
  output logic                               evicted,
  output logic signed [lfuc_pkg::KEY_W-1:0]  evicted_key
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int MW = (UW > lfuc_pkg::CAP_W) ? UW : lfuc_pkg::CAP_W;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  lfuc_pkg::state_t state, state_next;

  logic [lfuc_pkg::CAP_W-1:0]         capacity;
  logic [UW-1:0]                      used;
  logic                               op_q;
  logic signed [lfuc_pkg::KEY_W-1:0]  key_q;
  logic signed [lfuc_pkg::VAL_W-1:0]  value_q;
  logic [ENTRIES-1:0]                 match_q;

  // Cell chain
  logic [ENTRIES-1:0]                 cell_valid;
  logic [ENTRIES-1:0]                 cell_match;
  logic [ENTRIES-1:0]                 cell_gt;
  logic signed [lfuc_pkg::KEY_W-1:0]  cell_key   [ENTRIES];
  logic signed [lfuc_pkg::VAL_W-1:0]  cell_value [ENTRIES];
  logic [COUNT_BITS-1:0]              cell_count [ENTRIES];
  logic [ENTRIES-1:0]                 left_valid;
  logic [ENTRIES-1:0]                 left_gt;
  logic signed [lfuc_pkg::KEY_W-1:0]  left_key   [ENTRIES];
  logic signed [lfuc_pkg::VAL_W-1:0]  left_value [ENTRIES];
  logic [COUNT_BITS-1:0]              left_count [ENTRIES];

  // Update command
  logic                               finish;
  logic                               accept;
  logic                               commit;
  logic [IW-1:0]                      pos;
  logic [COUNT_BITS-1:0]              new_count;
  logic signed [lfuc_pkg::VAL_W-1:0]  new_value;
  logic                               used_inc;

  // Result of the current transaction
  logic                               hit_any;
  logic [IW-1:0]                      hit_idx;
  logic signed [lfuc_pkg::VAL_W-1:0]  hit_value;
  logic [COUNT_BITS-1:0]              hit_count;
  logic [COUNT_BITS-1:0]              bumped;
  logic [MW-1:0]                      cap_eff;
  logic                               full;
  logic [IW-1:0]                      last_idx;
  logic signed [lfuc_pkg::VAL_W-1:0]  res_value;
  logic                               res_evicted;
  logic signed [lfuc_pkg::KEY_W-1:0]  res_evkey;

  // Neighbour wiring; the head cell sees an empty left side
  always_comb begin
    left_valid[0] = 1'b0;
    left_gt[0]    = 1'b0;
    left_key[0]   = '0;
    left_value[0] = '0;
    left_count[0] = '0;
    for (int i = 1; i < ENTRIES; i++) begin
      left_valid[i] = cell_valid[i-1];
      left_gt[i]    = cell_gt[i-1];
      left_key[i]   = cell_key[i-1];
      left_value[i] = cell_value[i-1];
      left_count[i] = cell_count[i-1];
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfuc_cell #(
      .IDX        (g),
      .IW         (IW),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .commit     (commit),
      .pos        (pos),
      .new_count  (new_count),
      .key_in     (key_q),
      .value_in   (new_value),
      .left_valid (left_valid[g]),
      .left_key   (left_key[g]),
      .left_value (left_value[g]),
      .left_count (left_count[g]),
      .left_gt    (left_gt[g]),
      .valid      (cell_valid[g]),
      .key_out    (cell_key[g]),
      .value_out  (cell_value[g]),
      .count_out  (cell_count[g]),
      .match      (cell_match[g]),
      .gt         (cell_gt[g])
    );
  end

  // Hit selection from the registered match vector (at most one bit set)
  always_comb begin
    hit_any   = |match_q;
    hit_idx   = '0;
    hit_value = '0;
    hit_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_idx   = hit_idx | IW'(i);
        hit_value = hit_value | cell_value[i];
        hit_count = hit_count | cell_count[i];
      end
    end
    bumped = (hit_count == '1) ? hit_count : hit_count + COUNT_ONE;
  end

  // Occupancy against the effective capacity
  always_comb begin
    cap_eff  = (MW'(capacity) > MW'(ENTRIES)) ? MW'(ENTRIES) : MW'(capacity);
    full     = MW'(used) >= cap_eff;
    last_idx = IW'(used - UW'(1));
  end

  // Update decision
  always_comb begin
    commit      = 1'b0;
    pos         = hit_idx;
    new_count   = bumped;
    new_value   = value_q;
    used_inc    = 1'b0;
    res_value   = '0;
    res_evicted = 1'b0;
    res_evkey   = '0;
    if (op_q == lfuc_pkg::OP_GET) begin
      if (hit_any) begin
        commit    = finish;
        new_value = hit_value;
        res_value = hit_value;
      end
    end else if (capacity != '0) begin
      commit = finish;
      if (!hit_any) begin
        new_count = COUNT_ONE;
        if (full) begin
          pos         = last_idx;
          res_evicted = 1'b1;
          res_evkey   = cell_key[last_idx];
        end else begin
          pos      = IW'(used);
          used_inc = 1'b1;
        end
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfuc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    finish     = (state == lfuc_pkg::ST_UPD) && (!out_valid || !out_stall);
    in_stall   = !((state == lfuc_pkg::ST_IDLE) || finish);
    accept     = in_valid && !in_stall;
    state_next = state;
    case (state)
      lfuc_pkg::ST_IDLE: begin
        if (accept) state_next = lfuc_pkg::ST_LOOK;
      end
      lfuc_pkg::ST_LOOK: begin
        state_next = lfuc_pkg::ST_UPD;
      end
      lfuc_pkg::ST_UPD: begin
        if (finish) state_next = accept ? lfuc_pkg::ST_LOOK : lfuc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lfuc_pkg::ST_IDLE;
      end
    endcase
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfuc_pkg::CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_wdata;
    end
  end

  // Entries in use
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (commit && used_inc) begin
      used <= used + UW'(1);
    end
  end

  // Input capture and key compare
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      key_q   <= key;
      value_q <= value;
    end
    if (state == lfuc_pkg::ST_LOOK) begin
      match_q <= cell_match;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit         <= hit_any;
      read_value  <= res_value;
      evicted     <= res_evicted;
      evicted_key <= res_evkey;
    end
  end

`ifndef SYNTHESIS
  // A key is held by at most one cell
  a_match_onehot: assert property (@(posedge clk) disable iff (rst)
    state == lfuc_pkg::ST_UPD |-> $onehot0(match_q))
    else $error("more than one cell matched the key");

  // The occupancy count agrees with the valid cells
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(used))
    else $error("occupancy count out of step with valid cells");

  // Valid cells stay packed at the head of the chain
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + ENTRIES'(1)) & cell_valid) == '0)
    else $error("gap in the cell chain");

  // An eviction replaces in place and keeps occupancy unchanged
  a_evict_used: assert property (@(posedge clk) disable iff (rst)
    commit && res_evicted |=> $stable(used))
    else $error("eviction changed occupancy");
`endif

endmodule

// ===== rtl/core/lfuc_cell.sv =====
`timescale 1ns / 1ps

// One entry of the ordered chain. The chain is kept sorted by use count
// (highest first) and, within a count, most recent first. An update moves
// one entry from position pos to position q <= pos: cell q loads the
// new contents, cells q+1..pos take their left neighbour's contents.
module lfuc_cell #(
  parameter int IDX        = 0,
  parameter int IW         = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               commit,
  input  logic [IW-1:0]                      pos,
  input  logic [COUNT_BITS-1:0]              new_count,
  input  logic signed [lfuc_pkg::KEY_W-1:0]  key_in,
  input  logic signed [lfuc_pkg::VAL_W-1:0]  value_in,
  input  logic                               left_valid,
  input  logic signed [lfuc_pkg::KEY_W-1:0]  left_key,
  input  logic signed [lfuc_pkg::VAL_W-1:0]  left_value,
  input  logic [COUNT_BITS-1:0]              left_count,
  input  logic                               left_gt,
  output logic                               valid,
  output logic signed [lfuc_pkg::KEY_W-1:0]  key_out,
  output logic signed [lfuc_pkg::VAL_W-1:0]  value_out,
  output logic [COUNT_BITS-1:0]              count_out,
  output logic                               match,
  output logic                               gt
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic          HEAD   = (IDX == 0);

  logic below;
  logic reach;
  logic take_new;
  logic take_left;

  // Local placement decision: counts above the new count form a prefix
  always_comb begin
    below     = MY_IDX < pos;
    reach     = MY_IDX <= pos;
    gt        = valid && (count_out > new_count) && below;
    take_new  = reach && !gt && (HEAD || left_gt);
    take_left = reach && !gt && !take_new;
    match     = valid && (key_out == key_in);
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (commit && take_new) begin
      valid <= 1'b1;
    end else if (commit && take_left) begin
      valid <= left_valid;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (commit && take_new) begin
      key_out   <= key_in;
      value_out <= value_in;
      count_out <= new_count;
    end else if (commit && take_left) begin
      key_out   <= left_key;
      value_out <= left_value;
      count_out <= left_count;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int ENTRIES = 16;
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int HOLD_CYCLES = 90;
  localparam int PHASES = 10;
  localparam int DIR_ROWS = 38;

  typedef struct packed {
    logic                              hit;
    logic signed [lfuc_pkg::VAL_W-1:0] read_value;
    logic                              evicted;
    logic signed [lfuc_pkg::KEY_W-1:0] evicted_key;
  } lfu_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic         op;
    logic [31:0]  key;
    logic [31:0]  val;
    bit           fixed;
    lfu_result_t  res;
  } stim_row_t;

  localparam lfu_result_t NO_RES = '0;
  localparam lfu_result_t HIT_ONLY = '{1'b1, 32'h0, 1'b0, 32'h0};

  // Keys for the recency tie-break sequence
  localparam logic [31:0] TIE_KEY_A = 32'h5A5A_0001;
  localparam logic [31:0] TIE_KEY_B = 32'hA5A5_0002;
  localparam logic [31:0] TIE_KEY_C = 32'h0F0F_0003;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [lfuc_pkg::CAP_W-1:0]        cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              operation = lfuc_pkg::OP_GET;
  logic signed [lfuc_pkg::KEY_W-1:0] key = '0;
  logic signed [lfuc_pkg::VAL_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              hit;
  logic signed [lfuc_pkg::VAL_W-1:0] read_value;
  logic                              evicted;
  logic signed [lfuc_pkg::KEY_W-1:0] evicted_key;

  lfu_cache_lru_tiebreak #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .evicted_key(evicted_key)
  );

  always #5 clk = ~clk;

  // Cache shadow: slot contents, use counts and recency ages (0 = newest)
  logic                       slot_used [ENTRIES] = '{default: 1'b0};
  logic [31:0]                slot_key  [ENTRIES];
  logic [31:0]                slot_val  [ENTRIES];
  logic [COUNT_BITS-1:0]      slot_uses [ENTRIES];
  int unsigned                slot_age  [ENTRIES];
  logic [lfuc_pkg::CAP_W-1:0] cap_reg = lfuc_pkg::CAP_RESET;

  lfu_result_t           pending_results [$];
  logic signed [31:0]    key_pool [$];
  int                    mismatches = 0;
  bit                    idle_on = 1'b0;
  int                    hold_len = 0;
  int                    stall_left = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // equal counts on two keys: the new key pushes out the older one
    '{ROW_CFG,  lfuc_pkg::OP_GET, 32'h0,         32'd2,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, TIE_KEY_A,     32'h1111_1111, 1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, TIE_KEY_B,     32'h2222_2222, 1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, TIE_KEY_A,     32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, TIE_KEY_A,     32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, TIE_KEY_A,     32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, TIE_KEY_B,     32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, TIE_KEY_B,     32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, TIE_KEY_B,     32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, TIE_KEY_C,     32'h4444_4444, 1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, TIE_KEY_A,     32'h3333_3333, 1'b0, NO_RES},
    '{ROW_CFG,  lfuc_pkg::OP_GET, 32'h0,         32'd16,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0,         1'b1, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1,
      '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0,         1'b1,
      '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, HIT_ONLY},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'h0,         32'h0,         1'b1, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0,         1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    // zero capacity: puts change nothing but still report presence
    '{ROW_CFG,  lfuc_pkg::OP_GET, 32'h0,         32'd0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd5,         32'd1,         1'b1, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'd3,         1'b1, HIT_ONLY},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0,         1'b1,
      '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'd5,         32'h0,         1'b1, NO_RES},
    // small capacity, lowest count goes first
    '{ROW_CFG,  lfuc_pkg::OP_GET, 32'h0,         32'd2,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd1,         32'd10,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd2,         32'd20,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'd2,         32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd3,         32'd30,        1'b0, NO_RES},
    // capacity beyond the slot count
    '{ROW_CFG,  lfuc_pkg::OP_GET, 32'h0,         32'd31,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd4,         32'd40,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd5,         32'd50,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd6,         32'd60,        1'b0, NO_RES},
    // capacity dropped under occupancy: one eviction, oldest of the count-1 tie
    '{ROW_CFG,  lfuc_pkg::OP_GET, 32'h0,         32'd1,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_PUT, 32'd7,         32'd70,        1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'd4,         32'h0,         1'b0, NO_RES},
    '{ROW_ITEM, lfuc_pkg::OP_GET, 32'd3,         32'h0,         1'b0, NO_RES}
  };

  int phase_cap [PHASES] = '{16, 31, 3, 0, 1, 17, 5, 2, 8, 16};
  int phase_len [PHASES] = '{150, 150, 130, 60, 100, 150, 130, 100, 130, 150};

  // Make a slot the newest and bump its count, saturating
  function automatic void promote(input int idx);
    int unsigned r;
    r = slot_age[idx];
    for (int j = 0; j < ENTRIES; j++)
      if (slot_used[j] && j != idx && slot_age[j] < r) slot_age[j]++;
    slot_age[idx] = 0;
    if (slot_uses[idx] != COUNT_MAX) slot_uses[idx]++;
  endfunction

  // Expected result of one transaction, updating the shadow
  function automatic lfu_result_t lfu_predict(input logic op, input logic [31:0] k,
                                              input logic [31:0] v);
    lfu_result_t res;
    int found, used, victim, slot, limit;
    res = '0;
    found = -1;
    used = 0;
    victim = -1;
    slot = -1;
    limit = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        used++;
        if (found < 0 && slot_key[i] == k) found = i;
      end
    end
    res.hit = (found >= 0);
    if (op == lfuc_pkg::OP_GET) begin
      if (found >= 0) begin
        promote(found);
        res.read_value = slot_val[found];
      end
    end else if (limit != 0) begin
      if (found >= 0) begin
        promote(found);
        slot_val[found] = v;
      end else begin
        if (used >= limit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot_used[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
            slot_used[victim] = 1'b0;
            res.evicted = 1'b1;
            res.evicted_key = slot_key[victim];
            slot = victim;
          end
        end
        // lowest free slot otherwise
        if (slot < 0) begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i]) slot_age[i]++;
          slot_used[slot] = 1'b1;
          slot_key[slot] = k;
          slot_val[slot] = v;
          slot_uses[slot] = 1;
          slot_age[slot] = 0;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one transaction and hold it until taken
  task automatic send_item(input logic op, input logic [31:0] k, input logic [31:0] v,
                           input bit fixed, input lfu_result_t fixed_res);
    int gap;
    lfu_result_t guess;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_stall);
    guess = lfu_predict(op, k, v);
    pending_results.push_back(fixed ? fixed_res : guess);
  endtask

  // Stop offering and wait for all outstanding results
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lfuc_pkg::CAP_W-1:0] cap);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk) cfg_write <= 1'b0;
    cap_reg = cap;
  endtask

  // New key set per phase, keeping roughly half the previous one
  task automatic refresh_pool(input int n);
    logic signed [31:0] old [$];
    old = key_pool;
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      if (i < old.size() && $urandom_range(0, 1) == 1) key_pool.push_back(old[i]);
      else key_pool.push_back($urandom());
    end
  endtask

  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (roll < 95) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic run_phase(input int cap, input int n, input bit idle, input bit squeeze);
    int eff;
    logic op;
    write_capacity(cap[lfuc_pkg::CAP_W-1:0]);
    eff = (cap > ENTRIES) ? ENTRIES : cap;
    refresh_pool(eff + 5);
    idle_on = idle;
    if (squeeze) hold_len = HOLD_CYCLES;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 1) ? lfuc_pkg::OP_PUT : lfuc_pkg::OP_GET;
      send_item(op, pick_key(), $urandom(), 1'b0, NO_RES);
    end
  endtask

  // Output side back-pressure: random bursts plus the long hold-off
  always @(negedge clk) begin
    if (hold_len != 0) begin
      stall_left = hold_len;
      hold_len = 0;
    end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    lfu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing pending", evicted_key, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (evicted !== want.evicted) report_mismatch("evicted", evicted, want.evicted);
        if (evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", evicted_key, want.evicted_key);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed table
    idle_on = 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_capacity(dir_rows[r].val[lfuc_pkg::CAP_W-1:0]);
      else
        send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].val,
                  dir_rows[r].fixed, dir_rows[r].res);
    end

    // Random phases; the hold-off lands in the second, the last runs without idling
    for (int p = 0; p < PHASES; p++)
      run_phase(phase_cap[p], phase_len[p], p != 1 && p != PHASES - 1, p == 1);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("lfu_cache_lru_tiebreak verification clean");
    end else begin
      $display("lfu_cache_lru_tiebreak verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("lfu_cache_lru_tiebreak verification failed");
    $finish;
  end

endmodule
